// ===== hw/rtl/ogrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid ray march package
// Shared types, constants and the CORDIC arctangent table for the ray march.
// ----------------------------------------------------------------------------
package ogrm_pkg;

    localparam int GRID_SIDE_DEFAULT     = 256;
    localparam int CORDIC_STAGES_DEFAULT = 16;

    // Angles are radians in Q.30, carried in a signed word wide enough for a
    // heading plus a full bearing offset.
    localparam int ANG_W = 38;

    localparam logic signed [ANG_W-1:0] ANG_PI          = 38'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI      = 38'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI     = 38'sd1686629713;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = 38'sd652032874;

    localparam logic signed [7:0] HIT_LEVEL = 8'sd50;
    localparam logic [22:0]       MIN_CELL  = 23'd328;

    // Result codes.
    localparam logic [1:0] OUTCOME_HIT      = 2'd0;
    localparam logic [1:0] OUTCOME_LEFT_MAP = 2'd1;
    localparam logic [1:0] OUTCOME_RANGE    = 2'd2;
    localparam logic [1:0] OUTCOME_NO_MAP   = 2'd3;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_METER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT     = 3'd6;

    typedef struct packed {
        logic               op;
        logic [15:0]        cell_address;
        logic signed [7:0]  cell_occupancy;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] bearing;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [7:0]         hit_column;
        logic [7:0]         hit_row;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_ctl_t;

    // atan(2^-i) in Q.30, truncated.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 38'sd843314856;
            5'd1:    v = 38'sd497837829;
            5'd2:    v = 38'sd263043836;
            5'd3:    v = 38'sd133525158;
            5'd4:    v = 38'sd67021686;
            5'd5:    v = 38'sd33543515;
            5'd6:    v = 38'sd16775850;
            5'd7:    v = 38'sd8388437;
            5'd8:    v = 38'sd4194282;
            5'd9:    v = 38'sd2097149;
            5'd10:   v = 38'sd1048575;
            5'd11:   v = 38'sd524287;
            5'd12:   v = 38'sd262143;
            5'd13:   v = 38'sd131071;
            5'd14:   v = 38'sd65535;
            5'd15:   v = 38'sd32767;
            5'd16:   v = 38'sd16383;
            5'd17:   v = 38'sd8191;
            5'd18:   v = 38'sd4095;
            5'd19:   v = 38'sd2047;
            5'd20:   v = 38'sd1023;
            5'd21:   v = 38'sd511;
            5'd22:   v = 38'sd255;
            5'd23:   v = 38'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/occupancy_grid_ray_march_core.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid ray march core
// Holds an occupancy grid in RAM and casts rays through it to find the first
// occupied cell along a bearing from the robot pose.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready/s_data) takes one word per item. A word
//   with op = write stores one grid cell and gives no result.
//   A word with op = cast starts a ray and gives exactly one result word on the
//   output channel (m_valid/m_ready/m_data).
//   A cast runs through a set-up (quaternion sums, CORDIC atan2, angle wrap,
//   CORDIC sin/cos, step and slope multiplies), then marches one half-cell
//   step per cycle, since each step makes one read of the grid RAM and the
//   read of the previous step is checked in the same cycle. The march makes
//   up to about 1200 steps at default settings; a hit then also passes through
//   a goal state before the result. A zero yaw vector skips the atan2. A cast
//   before any cell was written goes straight to the output state and answers
//   "no map".
//   The input side is open again as soon as the result sits in the output
//   register, so a stalled receiver holds only the next cast; map writes keep
//   flowing while a result waits. Grid writes happen only between casts, so the
//   RAM never sees a read and a write of the same entry in flight together.
//   Reset (aresetn low, synchronous) clears the control state, restores the
//   configuration defaults and marks the map unloaded; the grid RAM itself is
//   not cleared. Configuration words are written through cfg_we; the user must
//   do so only while idle, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_march_core #(
    parameter int GRID_SIDE     = ogrm_pkg::GRID_SIDE_DEFAULT,
    parameter int CORDIC_STAGES = ogrm_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ogrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ogrm_pkg::in_word_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ogrm_pkg::out_word_t                m_data
);
    import ogrm_pkg::*;

    localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MX_W        = $clog2(GRID_SIDE);
    localparam int W_W         = $clog2(GRID_SIDE + 1);
    localparam int P_W         = 76;          // position times cells_per_meter
    localparam int IDX_FULL_W  = P_W - 32;
    localparam int D_W         = 26;          // per-step world increment

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_QSUM   = 4'd1;
    localparam logic [3:0] ST_ATAN   = 4'd2;
    localparam logic [3:0] ST_WRAP   = 4'd3;
    localparam logic [3:0] ST_FOLD   = 4'd4;
    localparam logic [3:0] ST_SINCOS = 4'd5;
    localparam logic [3:0] ST_MULX   = 4'd6;
    localparam logic [3:0] ST_MULY   = 4'd7;
    localparam logic [3:0] ST_RELX   = 4'd8;
    localparam logic [3:0] ST_RELY   = 4'd9;
    localparam logic [3:0] ST_DPX    = 4'd10;
    localparam logic [3:0] ST_DPY    = 4'd11;
    localparam logic [3:0] ST_MARCH  = 4'd12;
    localparam logic [3:0] ST_GOAL   = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    // Configuration.
    logic [8:0]         map_width_reg, map_height_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [22:0]        cell_size_reg;
    logic [23:0]        cpm_reg;
    logic [30:0]        range_limit_reg;

    // Control.
    logic [3:0] state_reg, state_next;
    logic       loaded_reg, pend_reg, neg_reg, m_valid_reg;
    out_word_t  res_reg, m_data_reg;

    // Cast datapath.
    logic signed [31:0]      rx_reg, ry_reg;
    logic signed [31:0]      p_wz_reg, p_xy_reg, p_yy_reg, p_zz_reg;
    logic signed [15:0]      bearing_reg;
    logic signed [ANG_W-1:0] theta_reg, cos_reg, sin_reg;
    logic signed [D_W-1:0]   dxs_reg, dys_reg;
    logic signed [P_W-1:0]   px_reg, py_reg, dpx_reg, dpy_reg;
    logic [31:0]             dist_reg;
    logic [MX_W-1:0]         pmx_reg, pmy_reg;

    // Combinational helpers.
    logic                    accept, cast_accept, write_accept;
    logic signed [32:0]      s_sum, c_sum;
    logic signed [ANG_W-1:0] siny, cosy, pre_x, pre_y, pre_z, bear_ang, fold_a;
    logic                    yaw_zero, fold_neg;
    logic [22:0]             cs_eff;
    logic [21:0]             step;
    logic signed [ANG_W-1:0] trig_sel;
    logic signed [60:0]      step_prod;
    logic signed [32:0]      rel0;
    logic signed [57:0]      rel_prod;
    logic signed [D_W-1:0]   d_sel;
    logic signed [D_W+24:0]  d_prod;
    logic [W_W-1:0]          w_eff, h_eff;
    logic [IDX_FULL_W-1:0]   mx_full, my_full;
    logic                    off_map, range_over, hit, issue;
    logic [MX_W-1:0]         mx_idx, my_idx;
    logic [ADDR_W-1:0]       rd_addr;
    logic [7:0]              rd_data;
    logic [MX_W+23:0]        gprod_x, gprod_y;

    cordic_ctl_t             cctl;
    logic signed [ANG_W-1:0] c_x_in, c_y_in, c_z_in, c_x, c_y, c_z;
    logic                    c_done;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign cast_accept  = accept && (s_data.op == OP_CAST);
    assign write_accept = accept && (s_data.op == OP_WRITE)
                          && (32'(s_data.cell_address) < 32'(STORE_DEPTH));

    // Yaw vector from the quaternion: 2(wz+xy), 1 - 2(y^2+z^2) in Q.28.
    always_comb begin
        s_sum    = 33'(p_wz_reg) + 33'(p_xy_reg);
        c_sum    = 33'(p_yy_reg) + 33'(p_zz_reg);
        siny     = ANG_W'(s_sum) <<< 1;
        cosy     = ANG_W'(268435456) - (ANG_W'(c_sum) <<< 1);
        yaw_zero = (siny == '0) && (cosy == '0);
        pre_x    = cosy;
        pre_y    = siny;
        pre_z    = '0;
        // A vector in the left half-plane is turned by a quarter turn first so
        // the CORDIC sweep covers it.
        if (cosy < 0) begin
            if (siny >= 0) begin
                pre_x = siny;
                pre_y = -cosy;
                pre_z = ANG_HALF_PI;
            end else begin
                pre_x = -siny;
                pre_y = cosy;
                pre_z = -ANG_HALF_PI;
            end
        end
        bear_ang = {{(ANG_W - 33){bearing_reg[15]}}, bearing_reg, 17'd0};
        fold_a   = theta_reg;
        fold_neg = 1'b0;
        if (theta_reg > ANG_HALF_PI) begin
            fold_a   = theta_reg - ANG_PI;
            fold_neg = 1'b1;
        end else if (theta_reg < -ANG_HALF_PI) begin
            fold_a   = theta_reg + ANG_PI;
            fold_neg = 1'b1;
        end
    end

    always_comb begin
        cctl.start     = 1'b0;
        cctl.vectoring = 1'b1;
        c_x_in         = pre_x;
        c_y_in         = pre_y;
        c_z_in         = pre_z;
        if (state_reg == ST_QSUM && !yaw_zero) begin
            cctl.start = 1'b1;
        end else if (state_reg == ST_FOLD) begin
            cctl.start     = 1'b1;
            cctl.vectoring = 1'b0;
            c_x_in         = CORDIC_GAIN_INV;
            c_y_in         = '0;
            c_z_in         = fold_a;
        end
    end

    ogrm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cctl),
        .x_in    (c_x_in),
        .y_in    (c_y_in),
        .z_in    (c_z_in),
        .done    (c_done),
        .x_out   (c_x),
        .y_out   (c_y),
        .z_out   (c_z)
    );

    // Step set-up: one multiplier each for the slope, the start point and the
    // per-step increment of position times cells_per_meter.
    always_comb begin
        cs_eff    = (cell_size_reg < MIN_CELL) ? MIN_CELL : cell_size_reg;
        step      = cs_eff[22:1];
        trig_sel  = (state_reg == ST_MULX) ? cos_reg : sin_reg;
        step_prod = 61'($signed({1'b0, step})) * 61'(trig_sel);
        rel0      = (state_reg == ST_RELX) ? (33'(rx_reg) - 33'(origin_x_reg))
                                           : (33'(ry_reg) - 33'(origin_y_reg));
        rel_prod  = 58'(rel0) * 58'($signed({1'b0, cpm_reg}));
        d_sel     = (state_reg == ST_DPX) ? dxs_reg : dys_reg;
        d_prod    = (D_W+25)'(d_sel) * (D_W+25)'($signed({1'b0, cpm_reg}));
    end

    // March step: cell indices are the upper bits of position times
    // cells_per_meter; the RAM read of the previous point is checked first.
    always_comb begin
        w_eff      = (32'(map_width_reg) > 32'(GRID_SIDE)) ? W_W'(GRID_SIDE)
                                                           : W_W'(map_width_reg);
        h_eff      = (32'(map_height_reg) > 32'(GRID_SIDE)) ? W_W'(GRID_SIDE)
                                                            : W_W'(map_height_reg);
        mx_full    = px_reg[P_W-1:32];
        my_full    = py_reg[P_W-1:32];
        off_map    = mx_full[IDX_FULL_W-1] || my_full[IDX_FULL_W-1]
                     || (mx_full >= IDX_FULL_W'(w_eff))
                     || (my_full >= IDX_FULL_W'(h_eff));
        range_over = dist_reg > {1'b0, range_limit_reg};
        hit        = pend_reg && ($signed(rd_data) >= HIT_LEVEL);
        mx_idx     = MX_W'(mx_full);
        my_idx     = MX_W'(my_full);
        rd_addr    = ADDR_W'(ADDR_W'(my_idx) * ADDR_W'(w_eff)) + ADDR_W'(mx_idx);
        issue      = (state_reg == ST_MARCH) && !hit && !range_over && !off_map;
        gprod_x    = (MX_W+24)'({pmx_reg, 1'b1}) * (MX_W+24)'(cell_size_reg);
        gprod_y    = (MX_W+24)'({pmy_reg, 1'b1}) * (MX_W+24)'(cell_size_reg);
    end

    ogrm_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_grid (
        .aclk  (aclk),
        .we    (write_accept),
        .waddr (ADDR_W'(s_data.cell_address)),
        .wdata (s_data.cell_occupancy),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cast_accept) begin
                    state_next = loaded_reg ? ST_QSUM : ST_OUT;
                end
            end
            ST_QSUM:   state_next = yaw_zero ? ST_WRAP : ST_ATAN;
            ST_ATAN:   if (c_done) state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_SINCOS;
            ST_SINCOS: if (c_done) state_next = ST_MULX;
            ST_MULX:   state_next = ST_MULY;
            ST_MULY:   state_next = ST_RELX;
            ST_RELX:   state_next = ST_RELY;
            ST_RELY:   state_next = ST_DPX;
            ST_DPX:    state_next = ST_DPY;
            ST_DPY:    state_next = ST_MARCH;
            ST_MARCH: begin
                if (hit) begin
                    state_next = ST_GOAL;
                end else if (range_over || off_map) begin
                    state_next = ST_OUT;
                end
            end
            ST_GOAL:   state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            loaded_reg      <= 1'b0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            map_width_reg   <= 9'd256;
            map_height_reg  <= 9'd256;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_size_reg   <= 23'd3277;
            cpm_reg         <= 24'd1310720;
            range_limit_reg <= 31'd1966080;
        end else begin
            state_reg <= state_next;
            if (write_accept) begin
                loaded_reg <= 1'b1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAP_WIDTH:       map_width_reg   <= cfg_wdata[8:0];
                    CFG_MAP_HEIGHT:      map_height_reg  <= cfg_wdata[8:0];
                    CFG_ORIGIN_X:        origin_x_reg    <= cfg_wdata;
                    CFG_ORIGIN_Y:        origin_y_reg    <= cfg_wdata;
                    CFG_CELL_SIZE:       cell_size_reg   <= cfg_wdata[22:0];
                    CFG_CELLS_PER_METER: cpm_reg         <= cfg_wdata[23:0];
                    CFG_RANGE_LIMIT:     range_limit_reg <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DPY) begin
                pend_reg <= 1'b0;
            end else if (state_reg == ST_MARCH) begin
                pend_reg <= issue;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cast_accept) begin
            rx_reg      <= s_data.robot_x;
            ry_reg      <= s_data.robot_y;
            p_wz_reg    <= 32'(s_data.quat_w) * 32'(s_data.quat_z);
            p_xy_reg    <= 32'(s_data.quat_x) * 32'(s_data.quat_y);
            p_yy_reg    <= 32'(s_data.quat_y) * 32'(s_data.quat_y);
            p_zz_reg    <= 32'(s_data.quat_z) * 32'(s_data.quat_z);
            bearing_reg <= s_data.bearing;
            res_reg     <= '{outcome: OUTCOME_NO_MAP, default: '0};
        end
        case (state_reg)
            ST_QSUM: begin
                if (yaw_zero) begin
                    theta_reg <= bear_ang;
                end
            end
            ST_ATAN: begin
                if (c_done) begin
                    theta_reg <= c_z + bear_ang;
                end
            end
            ST_WRAP: begin
                if (theta_reg > ANG_PI) begin
                    theta_reg <= theta_reg - ANG_TWO_PI;
                end else if (theta_reg < -ANG_PI) begin
                    theta_reg <= theta_reg + ANG_TWO_PI;
                end
            end
            ST_FOLD:   neg_reg <= fold_neg;
            ST_SINCOS: begin
                if (c_done) begin
                    cos_reg <= neg_reg ? -c_x : c_x;
                    sin_reg <= neg_reg ? -c_y : c_y;
                end
            end
            ST_MULX: dxs_reg <= step_prod[30 +: D_W];
            ST_MULY: dys_reg <= step_prod[30 +: D_W];
            ST_RELX: px_reg  <= P_W'(rel_prod);
            ST_RELY: py_reg  <= P_W'(rel_prod);
            ST_DPX:  dpx_reg <= P_W'(d_prod);
            ST_DPY: begin
                dpy_reg  <= P_W'(d_prod);
                dist_reg <= '0;
            end
            ST_MARCH: begin
                if (hit) begin
                    res_reg.outcome <= OUTCOME_HIT;
                end else if (range_over) begin
                    res_reg.outcome <= OUTCOME_RANGE;
                end else if (off_map) begin
                    res_reg.outcome <= OUTCOME_LEFT_MAP;
                end else begin
                    pmx_reg  <= mx_idx;
                    pmy_reg  <= my_idx;
                    px_reg   <= px_reg + dpx_reg;
                    py_reg   <= py_reg + dpy_reg;
                    dist_reg <= dist_reg + 32'(step);
                end
            end
            ST_GOAL: begin
                res_reg.goal_x     <= origin_x_reg + 32'(gprod_x >> 1);
                res_reg.goal_y     <= origin_y_reg + 32'(gprod_y >> 1);
                res_reg.hit_column <= 8'(pmx_reg);
                res_reg.hit_row    <= 8'(pmy_reg);
            end
            default: ;
        endcase
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A march only starts on a loaded map.
    a_march_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARCH) |-> loaded_reg)
        else $error("march running without a loaded map");

    // Any result other than a hit carries zero goal and indices.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.outcome != OUTCOME_HIT) |->
        (m_data.goal_x == '0 && m_data.goal_y == '0
         && m_data.hit_column == '0 && m_data.hit_row == '0))
        else $error("non-hit result with nonzero goal fields");

    // The rotation CORDIC is always started inside its convergence range.
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> (fold_a <= ANG_HALF_PI && fold_a >= -ANG_HALF_PI))
        else $error("sin/cos angle outside a quarter turn");

    // Distance only grows while marching.
    a_dist_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARCH && $past(state_reg) == ST_MARCH)
        |-> (dist_reg >= $past(dist_reg)))
        else $error("march distance went backwards");

endmodule

// ===== hw/rtl/ogrm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ogrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/ogrm_cordic.sv =====
// ----------------------------------------------------------------------------
// Iterative CORDIC unit
// One micro-rotation per cycle, in vectoring (atan2) or rotation (sin/cos) mode.
// ----------------------------------------------------------------------------
module ogrm_cordic #(
    parameter int STAGES = ogrm_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ogrm_pkg::cordic_ctl_t             ctl,
    input  logic signed [ogrm_pkg::ANG_W-1:0] x_in,
    input  logic signed [ogrm_pkg::ANG_W-1:0] y_in,
    input  logic signed [ogrm_pkg::ANG_W-1:0] z_in,
    output logic                              done,
    output logic signed [ogrm_pkg::ANG_W-1:0] x_out,
    output logic signed [ogrm_pkg::ANG_W-1:0] y_out,
    output logic signed [ogrm_pkg::ANG_W-1:0] z_out
);
    import ogrm_pkg::*;

    localparam int IT_W = $clog2(STAGES);

    logic signed [ANG_W-1:0] x_reg, y_reg, z_reg;
    logic signed [ANG_W-1:0] x_next, y_next, z_next;
    logic signed [ANG_W-1:0] xs, ys, at;
    logic [IT_W-1:0]         iter_reg;
    logic                    run_reg, vec_reg, done_reg, ccw;

    always_comb begin
        xs  = x_reg >>> iter_reg;
        ys  = y_reg >>> iter_reg;
        at  = atan_entry(5'(iter_reg));
        // Vectoring drives y toward zero; rotation drives the residual angle to zero.
        ccw = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        if (ccw) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            vec_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                run_reg  <= 1'b1;
                iter_reg <= '0;
                vec_reg  <= ctl.vectoring;
            end else if (run_reg) begin
                if (iter_reg == IT_W'(STAGES - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end else if (run_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
